### rtl/lpfc_pkg.sv
`timescale 1ns / 1ps
// lpfc_pkg: shared widths, constants, command and status types and the
// output saturation function of the low-pass feedback comb filter
// no dependencies
package lpfc_pkg;

    // field and register widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 32;
    localparam int PAIR_W   = 2 * SAMPLE_W;
    localparam int DWORDS_W = 12;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_W   = 14;
    localparam int PROD_W   = GAIN_W + SAMPLE_W;
    localparam int STEP_W   = 3;

    // default delay memory depth in sample pairs
    localparam int DELAY_DEPTH_DEF = 2048;

    // reset value of the delay length register
    localparam logic [DWORDS_W-1:0] DELAY_WORDS_RST = DWORDS_W'(2048);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DIRECT_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREV_INPUT_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREV_OUTPUT_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMB_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_WORDS      = 3'd4;

    typedef logic [STEP_W-1:0] step_t;

    // product terms, one per multiplier step; the low two bits pick the gain
    localparam step_t TERM_DIRECT_FIRST   = 3'd0;
    localparam step_t TERM_PREV_IN_FIRST  = 3'd1;
    localparam step_t TERM_PREV_OUT_FIRST = 3'd2;
    localparam step_t TERM_COMB_FIRST     = 3'd3;
    localparam step_t TERM_DIRECT_SECOND  = 3'd4;
    localparam step_t TERM_PREV_IN_SECOND = 3'd5;
    localparam step_t TERM_PREV_OUT_SECOND = 3'd6;
    localparam step_t TERM_COMB_SECOND    = 3'd7;

    // controller to datapath
    typedef struct packed {
        logic  clear;   // clearing pass, write one zero entry
        logic  start;   // word accepted: latch samples, advance ring, read memory
        logic  mul;     // multiply the term selected by step
        logic  add;     // accumulate the registered product
        logic  mid;     // close the first sample of the pair
        logic  finish;  // close the second sample, load output, write back
        step_t step;
    } lpfc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } lpfc_sts_t;

    // arithmetic shift right by the fraction width, saturate to signed 16
    function automatic logic [SAMPLE_W-1:0] sat_shift(input logic [GAIN_W-1:0] acc);
        logic [SAMPLE_W-1:0] res;
        if ((acc[31] == acc[30]) && (acc[30] == acc[29]))
            res = acc[29:14];
        else if (acc[31])
            res = 16'h8000;
        else
            res = 16'h7FFF;
        return res;
    endfunction

endpackage

### rtl/lpfc_if.sv
`timescale 1ns / 1ps
// lpfc_if: valid/ready channels of the comb filter: sample words in,
// filtered words out, configuration writes
// depends on lpfc_pkg
interface lpfc_in_if;
    logic                          valid;
    logic                          ready;
    logic [lpfc_pkg::SAMPLE_W-1:0] sample_first;
    logic [lpfc_pkg::SAMPLE_W-1:0] sample_second;

    modport source (output valid, output sample_first, output sample_second, input ready);
    modport sink   (input valid, input sample_first, input sample_second, output ready);
endinterface

interface lpfc_out_if;
    logic                          valid;
    logic                          ready;
    logic [lpfc_pkg::SAMPLE_W-1:0] out_first;
    logic [lpfc_pkg::SAMPLE_W-1:0] out_second;

    modport source (output valid, output out_first, output out_second, input ready);
    modport sink   (input valid, input out_first, input out_second, output ready);
endinterface

interface lpfc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lpfc_pkg::CFG_IDX_W-1:0] index;
    logic [lpfc_pkg::GAIN_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/lowpass_feedback_comb_filter_core.sv
`timescale 1ns / 1ps
// lowpass_feedback_comb_filter_core: top level of one low-pass feedback comb stage
// depends on lpfc_pkg, lpfc_if, lpfc_ctrl and lpfc_datapath
//
// After reset the delay memory is zero filled, one entry a cycle, so samples.ready
// stays low until all DELAY_DEPTH entries (2048 by default) are cleared;
// configuration writes are taken throughout. Each sample word is then handled in
// order: on acceptance the ring advances and the delay memory is read, a single
// 32x16 multiplier forms the eight gain terms one by one, and a final step closes
// the second sample, loads the output register and writes the word back. The next
// word is accepted on the following cycle at the earliest; no new word is taken
// while one is in progress. A finished word waits in the output register while the
// next word is accepted; the stage only stalls in its final cycle if that register is
// still full. Write configuration only while the stage is idle; a write to any gain
// clears the filter history but keeps the delay memory and ring position.
module lowpass_feedback_comb_filter_core #(
    parameter int DELAY_DEPTH = lpfc_pkg::DELAY_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lpfc_in_if.sink    samples,
    lpfc_out_if.source results,
    lpfc_cfg_if.sink   cfg
);
    import lpfc_pkg::*;

    lpfc_cmd_t cmd;
    lpfc_sts_t sts;
    logic      cfg_we;

    // configuration writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    // sequencer
    lpfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // arithmetic, state and delay memory
    lpfc_datapath #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .sample_first  (samples.sample_first),
        .sample_second (samples.sample_second),
        .cmd           (cmd),
        .sts           (sts),
        .out_first     (results.out_first),
        .out_second    (results.out_second)
    );

endmodule

### rtl/lpfc_ram.sv
`timescale 1ns / 1ps
// lpfc_ram: generic single write port, single read port RAM with
// registered read data
// no dependencies
module lpfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/lpfc_datapath.sv
`timescale 1ns / 1ps
// lpfc_datapath: gain registers, ring position, shared 32x16 multiplier,
// accumulator, history registers, output word register and delay memory
// depends on lpfc_pkg and lpfc_ram
module lpfc_datapath #(
    parameter int DELAY_DEPTH = lpfc_pkg::DELAY_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lpfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpfc_pkg::GAIN_W-1:0]    cfg_data,
    input  logic [lpfc_pkg::SAMPLE_W-1:0]  sample_first,
    input  logic [lpfc_pkg::SAMPLE_W-1:0]  sample_second,
    input  lpfc_pkg::lpfc_cmd_t            cmd,
    output lpfc_pkg::lpfc_sts_t            sts,
    output logic [lpfc_pkg::SAMPLE_W-1:0]  out_first,
    output logic [lpfc_pkg::SAMPLE_W-1:0]  out_second
);
    import lpfc_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int LW = (AW + 1 > DWORDS_W) ? AW + 1 : DWORDS_W;

    // configuration
    logic [GAIN_W-1:0]   direct_gain_reg;
    logic [GAIN_W-1:0]   prev_input_gain_reg;
    logic [GAIN_W-1:0]   prev_output_gain_reg;
    logic [GAIN_W-1:0]   comb_gain_reg;
    logic [DWORDS_W-1:0] delay_words_reg;

    // filter state
    logic [AW-1:0]     ring_pos_reg;
    logic [AW-1:0]     ring_pos_next;
    logic [PAIR_W-1:0] last_in_reg;
    logic [PAIR_W-1:0] last_out_reg;
    logic [FRAC_W-1:0] residue_reg;
    logic [AW-1:0]     clr_addr_reg;

    // working registers
    logic [SAMPLE_W-1:0]      x_first_reg;
    logic [SAMPLE_W-1:0]      x_second_reg;
    logic signed [PROD_W-1:0] product_reg;
    logic [GAIN_W-1:0]        acc_reg;
    logic [GAIN_W-1:0]        acc_sum;
    logic [SAMPLE_W-1:0]      y_first_reg;
    logic [SAMPLE_W-1:0]      y_second_sat;
    logic [SAMPLE_W-1:0]      out_first_reg;
    logic [SAMPLE_W-1:0]      out_second_reg;

    // multiplier operands
    logic [GAIN_W-1:0]   mul_gain;
    logic [SAMPLE_W-1:0] mul_sample;

    // delay memory ports
    logic              ram_we;
    logic [AW-1:0]     ram_wr_addr;
    logic [PAIR_W-1:0] ram_wr_data;
    logic [PAIR_W-1:0] delayed;

    logic          gain_write;
    logic [LW-1:0] pos_inc;
    logic          pos_wrap;

    assign gain_write = cfg_we && ((cfg_index == REG_DIRECT_GAIN)
                                || (cfg_index == REG_PREV_INPUT_GAIN)
                                || (cfg_index == REG_PREV_OUTPUT_GAIN)
                                || (cfg_index == REG_COMB_GAIN));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direct_gain_reg      <= '0;
            prev_input_gain_reg  <= '0;
            prev_output_gain_reg <= '0;
            comb_gain_reg        <= '0;
            delay_words_reg      <= DELAY_WORDS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIRECT_GAIN:      direct_gain_reg      <= cfg_data;
                REG_PREV_INPUT_GAIN:  prev_input_gain_reg  <= cfg_data;
                REG_PREV_OUTPUT_GAIN: prev_output_gain_reg <= cfg_data;
                REG_COMB_GAIN:        comb_gain_reg        <= cfg_data;
                REG_DELAY_WORDS:      delay_words_reg      <= cfg_data[DWORDS_W-1:0];
                default:              ;
            endcase
        end
    end

    // ring advance; a length of zero or past the depth wraps like the end
    assign pos_inc  = LW'(ring_pos_reg) + LW'(1);
    assign pos_wrap = (pos_inc >= LW'(delay_words_reg)) || (pos_inc >= LW'(DELAY_DEPTH));
    assign ring_pos_next = pos_wrap ? '0 : pos_inc[AW-1:0];

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    assign sts.clear_last = (clr_addr_reg == AW'(DELAY_DEPTH - 1));

    // operand select: the low step bits pick the gain
    always_comb
    begin
        case (cmd.step[1:0])
            2'd0:    mul_gain = direct_gain_reg;
            2'd1:    mul_gain = prev_input_gain_reg;
            2'd2:    mul_gain = prev_output_gain_reg;
            default: mul_gain = comb_gain_reg;
        endcase
        case (cmd.step)
            TERM_DIRECT_FIRST:    mul_sample = x_first_reg;
            TERM_PREV_IN_FIRST:   mul_sample = last_in_reg[PAIR_W-1:SAMPLE_W];
            TERM_PREV_OUT_FIRST:  mul_sample = last_out_reg[PAIR_W-1:SAMPLE_W];
            TERM_COMB_FIRST:      mul_sample = delayed[SAMPLE_W-1:0];
            TERM_DIRECT_SECOND:   mul_sample = x_second_reg;
            TERM_PREV_IN_SECOND:  mul_sample = x_first_reg;
            TERM_PREV_OUT_SECOND: mul_sample = y_first_reg;
            TERM_COMB_SECOND:     mul_sample = delayed[PAIR_W-1:SAMPLE_W];
            default:              mul_sample = x_first_reg;
        endcase
    end

    // shared multiplier, product registered
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            product_reg <= $signed(mul_gain) * $signed(mul_sample);
        end
    end

    // wrapping accumulate of product bits 16..47
    assign acc_sum      = acc_reg + product_reg[PROD_W-1:SAMPLE_W];
    assign y_second_sat = sat_shift(acc_sum);

    // word latch and accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_first_reg  <= sample_first;
            x_second_reg <= sample_second;
            acc_reg      <= GAIN_W'(residue_reg);
        end
        else if (cmd.add && cmd.mid)
        begin
            acc_reg     <= GAIN_W'(acc_sum[FRAC_W-1:0]);
            y_first_reg <= sat_shift(acc_sum);
        end
        else if (cmd.add)
        begin
            acc_reg <= acc_sum;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_first_reg  <= y_first_reg;
            out_second_reg <= y_second_sat;
        end
    end

    // filter history; a gain write restarts it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_pos_reg <= '0;
            last_in_reg  <= '0;
            last_out_reg <= '0;
            residue_reg  <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                ring_pos_reg <= ring_pos_next;
            end
            if (gain_write)
            begin
                last_in_reg  <= '0;
                last_out_reg <= '0;
                residue_reg  <= '0;
            end
            else if (cmd.finish)
            begin
                last_in_reg  <= {x_second_reg, x_first_reg};
                last_out_reg <= {y_second_sat, y_first_reg};
                residue_reg  <= acc_sum[FRAC_W-1:0];
            end
        end
    end

    // delay memory: zero fill during the clearing pass, else write back
    assign ram_we      = cmd.clear || cmd.finish;
    assign ram_wr_addr = cmd.clear ? clr_addr_reg : ring_pos_reg;
    assign ram_wr_data = cmd.clear ? '0 : {y_second_sat, y_first_reg};

    lpfc_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.start),
        .rd_addr (ring_pos_next),
        .rd_data (delayed)
    );

    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;

endmodule

### rtl/lpfc_ctrl.sv
`timescale 1ns / 1ps
// lpfc_ctrl: sequencer of the comb filter: clearing pass, word accept,
// eight multiplier steps, finish and output valid
// depends on lpfc_pkg
module lpfc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output lpfc_pkg::lpfc_cmd_t cmd,
    input  lpfc_pkg::lpfc_sts_t sts
);
    import lpfc_pkg::*;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // step that adds the last product of the first sample
    localparam step_t STEP_MID  = TERM_DIRECT_SECOND;
    localparam step_t STEP_LAST = TERM_COMB_SECOND;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    step_t      step_reg;
    step_t      step_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.step       = step_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    step_next  = TERM_DIRECT_FIRST;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.mul   = 1'b1;
                cmd.add   = (step_reg != TERM_DIRECT_FIRST);
                cmd.mid   = (step_reg == STEP_MID);
                step_next = step_reg + step_t'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.add        = 1'b1;
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= TERM_DIRECT_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### test/lpfc_tb_pkg.sv
`timescale 1ns / 1ps
// lpfc_tb_pkg: sample word types and the scoreboard of the comb filter bench,
// which predicts each filtered word and checks what the stage returns
// depends on lpfc_pkg
package lpfc_tb_pkg;
    import lpfc_pkg::*;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [GAIN_W-1:0]   gain_t;

    // first sample in the low half, as held in the delay memory
    typedef struct packed {
        sample_t second;
        sample_t first;
    } pair_t;

    localparam int OUT_MAX      = 2 ** (SAMPLE_W - 1) - 1;
    localparam int OUT_MIN      = -(2 ** (SAMPLE_W - 1));

    class comb_scoreboard;
        gain_t               direct_gain;
        gain_t               prev_in_gain;
        gain_t               prev_out_gain;
        gain_t               comb_gain;
        logic [DWORDS_W-1:0] delay_len;

        pair_t               delay_line [DELAY_DEPTH_DEF];
        int unsigned         ring_pos;
        pair_t               last_in;
        pair_t               last_out;
        logic [FRAC_W-1:0]   frac_carry;

        pair_t               expected_pairs [$];
        int                  mismatches;

        function new();
            direct_gain   = '0;
            prev_in_gain  = '0;
            prev_out_gain = '0;
            comb_gain     = '0;
            delay_len     = DELAY_WORDS_RST;
            foreach (delay_line[i])
                delay_line[i] = '0;
            ring_pos   = 0;
            last_in    = '0;
            last_out   = '0;
            frac_carry = '0;
            mismatches = 0;
        endfunction

        // register write; any gain write drops the filter history
        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input gain_t value);
            case (idx)
                REG_DIRECT_GAIN:      direct_gain   = value;
                REG_PREV_INPUT_GAIN:  prev_in_gain  = value;
                REG_PREV_OUTPUT_GAIN: prev_out_gain = value;
                REG_COMB_GAIN:        comb_gain     = value;
                REG_DELAY_WORDS:
                begin
                    delay_len = value[DWORDS_W-1:0];
                    return;
                end
                default: return;
            endcase
            last_in    = '0;
            last_out   = '0;
            frac_carry = '0;
        endfunction

        // accumulate the upper 32 bits of a 32x16 product, wrapping
        static function gain_t add_term(input gain_t acc, input gain_t gain,
                                        input sample_t smp);
            logic signed [PROD_W-1:0] prod;
            prod = $signed(gain) * $signed(smp);
            return acc + prod[PROD_W-1:SAMPLE_W];
        endfunction

        // drop the fraction and clamp to the sample range
        static function sample_t round_out(input gain_t acc);
            logic signed [GAIN_W-1:0] scaled;
            scaled = $signed(acc) >>> FRAC_W;
            if (scaled > OUT_MAX)
                scaled = OUT_MAX;
            else if (scaled < OUT_MIN)
                scaled = OUT_MIN;
            return scaled[SAMPLE_W-1:0];
        endfunction

        // accepted input word: advance the ring and work out the filtered word
        function void take_pair(input pair_t x);
            int unsigned len;
            int unsigned pos;
            pair_t       delayed;
            pair_t       y;
            gain_t       acc;
            len = delay_len;
            if (len > DELAY_DEPTH_DEF)
                len = DELAY_DEPTH_DEF;
            pos = ring_pos + 1;
            if (pos >= len || pos >= DELAY_DEPTH_DEF)
                pos = 0;
            ring_pos = pos;
            delayed  = delay_line[pos];

            // first sample carries on from the last sample of the previous word
            acc = GAIN_W'(frac_carry);
            acc = add_term(acc, direct_gain, x.first);
            acc = add_term(acc, prev_in_gain, last_in.second);
            acc = add_term(acc, prev_out_gain, last_out.second);
            acc = add_term(acc, comb_gain, delayed.first);
            y.first = round_out(acc);

            // second sample uses the first of this word as its history
            acc = GAIN_W'(acc[FRAC_W-1:0]);
            acc = add_term(acc, direct_gain, x.second);
            acc = add_term(acc, prev_in_gain, x.first);
            acc = add_term(acc, prev_out_gain, y.first);
            acc = add_term(acc, comb_gain, delayed.second);
            y.second   = round_out(acc);
            frac_carry = acc[FRAC_W-1:0];

            last_in         = x;
            last_out        = y;
            delay_line[pos] = y;
            expected_pairs.push_back(y);
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        task report_mismatch(input string msg);
            $display("%0t ns: %s", $time, msg);
            mismatches++;
        endtask

        // returned word against the oldest prediction
        task check_pair(input pair_t got);
            pair_t want;
            if (expected_pairs.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %h", got));
                return;
            end
            want = expected_pairs.pop_front();
            if (got.first !== want.first)
                report_mismatch($sformatf("out_first %h, predicted %h", got.first, want.first));
            if (got.second !== want.second)
                report_mismatch($sformatf("out_second %h, predicted %h",
                                          got.second, want.second));
        endtask
    endclass

endpackage

### test/tb.sv
`timescale 1ns / 1ps
// tb: drives sample words and register writes into the comb filter stage and
// checks every filtered word against the scoreboard's prediction
// depends on lpfc_pkg, lpfc_if, lpfc_tb_pkg and lowpass_feedback_comb_filter_core
module tb;
    import lpfc_pkg::*;
    import lpfc_tb_pkg::*;

    localparam int      CLK_HALF       = 6;
    localparam int      RESET_CYCLES   = 6;
    localparam int      SETTLE_CYCLES  = 16;
    localparam int      LONG_HOLD      = 300;
    localparam int      TIMEOUT_CYCLES = 400000;
    localparam int      RANDOM_PHASES  = 11;
    localparam int      PHASE_WORDS    = 110;
    localparam int      HOLD_WORDS     = 60;
    localparam int      FINAL_WORDS    = 230;
    localparam int      MAX_BURST      = 11;
    localparam sample_t SAMPLE_MAX     = 16'h7FFF;
    localparam sample_t SAMPLE_MIN     = 16'h8000;
    localparam gain_t   GAIN_MAX       = 32'h7FFF_FFFF;
    localparam gain_t   GAIN_MIN       = 32'h8000_0000;
    localparam gain_t   GAIN_UNITY     = 32'h4000_0000;
    localparam gain_t   GAIN_HALF      = 32'h2000_0000;
    localparam gain_t   GAIN_QUARTER   = 32'h1000_0000;
    localparam gain_t   DWORDS_MASK    = 2 ** DWORDS_W - 1;
    localparam int      CFG_IDX_TOP    = 2 ** CFG_IDX_W - 1;

    logic clk;
    logic rst_n;

    lpfc_in_if  in_ch ();
    lpfc_out_if out_ch ();
    lpfc_cfg_if cfg_ch ();

    lowpass_feedback_comb_filter_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (in_ch),
        .results (out_ch),
        .cfg     (cfg_ch)
    );

    comb_scoreboard sb = new();

    bit          send_idle_on;
    bit          recv_idle_on;
    int unsigned recv_hold;
    int unsigned recv_stall;

    // clock
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // run limit
    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("lowpass_feedback_comb_filter_core: mismatch");
        $finish;
    end

    // result side: check each accepted word, then choose the next ready
    initial
    begin
        recv_hold  = 0;
        recv_stall = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                sb.check_pair({out_ch.out_second, out_ch.out_first});
            if (recv_hold != 0)
            begin
                recv_hold--;
                out_ch.ready <= 1'b0;
            end
            else if (recv_stall != 0)
            begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end
            else if (recv_idle_on && $urandom_range(0, 9) == 0)
            begin
                recv_stall = $urandom_range(1, MAX_BURST) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    function automatic pair_t mk_pair(input sample_t a, input sample_t b);
        return {b, a};
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 5))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return sample_t'($urandom_range(0, 512) - 256);
            default: return sample_t'($urandom());
        endcase
    endfunction

    function automatic gain_t pick_gain();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return GAIN_MAX;
            2:       return GAIN_MIN;
            3:       return '0;
            4:       return GAIN_UNITY;
            default: return $urandom_range(0, 2 * GAIN_HALF) - GAIN_HALF;
        endcase
    endfunction

    // mostly short delays so the feedback path comes round often
    function automatic gain_t pick_delay();
        gain_t len;
        case ($urandom_range(0, 8))
            0:       len = 0;
            1:       len = 1;
            2:       len = DELAY_DEPTH_DEF;
            3:       len = DWORDS_MASK;
            4:       len = $urandom_range(DELAY_DEPTH_DEF + 1, DWORDS_MASK);
            default: len = $urandom_range(2, 24);
        endcase
        // bits above the register width are ignored by the stage
        return ($urandom() & ~DWORDS_MASK) | len;
    endfunction

    // offer one word, with an occasional gap in front of it
    task automatic send_pair(input pair_t x);
        if (send_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.sample_first  <= x.first;
        in_ch.sample_second <= x.second;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sb.take_pair(x);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input gain_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.write_reg(idx, value);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering and wait until every predicted word has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int words);
        drain_results();
        send_idle_on = $urandom_range(0, 3) != 0;
        recv_idle_on = $urandom_range(0, 3) != 0;
        for (int i = 0; i <= REG_DELAY_WORDS; i++)
            if ($urandom_range(0, 3) != 0)
                write_cfg(CFG_IDX_W'(i),
                          (i == REG_DELAY_WORDS) ? pick_delay() : pick_gain());
        if ($urandom_range(0, 3) == 0)
            write_cfg(CFG_IDX_W'($urandom_range(REG_DELAY_WORDS + 1, CFG_IDX_TOP)),
                      $urandom());
        for (int n = 0; n < words; n++)
        begin
            // now and then let the stage empty out in the middle of a phase
            if (n == words / 2 && $urandom_range(0, 2) == 0)
                drain_results();
            send_pair(mk_pair(pick_sample(), pick_sample()));
        end
    endtask

    // stimulus
    initial
    begin
        in_ch.valid         <= 1'b0;
        in_ch.sample_first  <= '0;
        in_ch.sample_second <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        rst_n               <= 1'b0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain pass-through with a short comb, written during the clearing pass
        write_cfg(REG_DELAY_WORDS, 4);
        write_cfg(REG_DIRECT_GAIN, GAIN_UNITY);
        write_cfg(REG_PREV_INPUT_GAIN, '0);
        write_cfg(REG_PREV_OUTPUT_GAIN, '0);
        write_cfg(REG_COMB_GAIN, GAIN_HALF);
        send_pair(mk_pair(16'h0000, 16'h0000));
        send_pair(mk_pair(SAMPLE_MAX, SAMPLE_MIN));
        send_pair(mk_pair(SAMPLE_MIN, SAMPLE_MAX));
        send_pair(mk_pair(16'h0001, 16'hFFFF));
        send_pair(mk_pair(16'h1234, 16'hEDCB));
        send_pair(mk_pair(16'h0000, 16'h0000));
        send_pair(mk_pair(16'h0000, 16'h0000));

        // extreme gains drive both saturation limits; zero delay length
        drain_results();
        write_cfg(REG_DIRECT_GAIN, GAIN_MAX);
        write_cfg(REG_PREV_INPUT_GAIN, GAIN_MIN);
        write_cfg(REG_PREV_OUTPUT_GAIN, GAIN_MAX);
        write_cfg(REG_COMB_GAIN, GAIN_MIN);
        write_cfg(REG_DELAY_WORDS, 0);
        send_pair(mk_pair(SAMPLE_MIN, SAMPLE_MIN));
        send_pair(mk_pair(SAMPLE_MAX, SAMPLE_MAX));
        send_pair(mk_pair(SAMPLE_MIN, SAMPLE_MAX));
        send_pair(mk_pair(16'h0000, 16'h0000));

        // delay length above the memory depth, then full depth; unused indexes
        drain_results();
        write_cfg(REG_DIRECT_GAIN, GAIN_MIN);
        write_cfg(REG_DELAY_WORDS, DWORDS_MASK);
        write_cfg(REG_DELAY_WORDS + CFG_IDX_W'(1), GAIN_MAX);
        write_cfg(CFG_IDX_W'(CFG_IDX_TOP), GAIN_MIN);
        send_pair(mk_pair(SAMPLE_MAX, SAMPLE_MIN));
        send_pair(mk_pair(16'h0001, 16'h0001));
        drain_results();
        write_cfg(REG_DELAY_WORDS, DELAY_DEPTH_DEF);
        send_pair(mk_pair(16'h0100, 16'hFF00));

        // ring position left beyond a shortened delay length
        drain_results();
        write_cfg(REG_DIRECT_GAIN, GAIN_UNITY);
        write_cfg(REG_PREV_INPUT_GAIN, -GAIN_QUARTER);
        write_cfg(REG_PREV_OUTPUT_GAIN, GAIN_QUARTER);
        write_cfg(REG_COMB_GAIN, GAIN_HALF);
        write_cfg(REG_DELAY_WORDS, 6);
        send_pair(mk_pair(16'h4000, 16'hC000));
        send_pair(mk_pair(16'h2000, 16'hE000));
        drain_results();
        write_cfg(REG_DELAY_WORDS, 2);
        send_pair(mk_pair(16'h0800, 16'hF800));
        send_pair(mk_pair(16'h0000, 16'h0000));
        send_pair(mk_pair(16'h7000, 16'h9000));

        // random settings and words
        repeat (RANDOM_PHASES) random_phase(PHASE_WORDS);

        // output held off for a long stretch while words keep coming
        drain_results();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b1;
        write_cfg(REG_DELAY_WORDS, $urandom_range(2, 24));
        recv_hold = LONG_HOLD;
        repeat (HOLD_WORDS) send_pair(mk_pair(pick_sample(), pick_sample()));

        // last stretch at full rate on both sides
        drain_results();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        write_cfg(REG_DIRECT_GAIN, pick_gain());
        write_cfg(REG_PREV_INPUT_GAIN, pick_gain());
        write_cfg(REG_PREV_OUTPUT_GAIN, pick_gain());
        write_cfg(REG_COMB_GAIN, pick_gain());
        write_cfg(REG_DELAY_WORDS, pick_delay());
        repeat (FINAL_WORDS) send_pair(mk_pair(pick_sample(), pick_sample()));

        drain_results();
        if (sb.mismatches == 0)
            $display("lowpass_feedback_comb_filter_core: match");
        else
            $display("lowpass_feedback_comb_filter_core: mismatch");
        $finish;
    end

endmodule

### filelist.f
rtl/lpfc_pkg.sv
rtl/lpfc_if.sv
rtl/lpfc_ram.sv
rtl/lpfc_datapath.sv
rtl/lpfc_ctrl.sv
rtl/lowpass_feedback_comb_filter_core.sv
test/lpfc_tb_pkg.sv
test/tb.sv
